[rtl/core/abod_pkg.sv]
// Shared types, constants and arithmetic helpers for the beat onset detector.
package abod_pkg;

  localparam int unsigned LevelW = 17;
  localparam int unsigned SampleW = 8;

  localparam logic [LevelW-1:0] SumMax = 17'h1FFFF;
  localparam logic [LevelW-1:0] MinLevelReset = 17'd9216;

  // Input word: one stereo sample pair.
  typedef struct packed {
    logic [SampleW-1:0] left_sample;
    logic [SampleW-1:0] right_sample;
    logic               frame_end;
  } abod_in_t;

  // Result word: one per frame.
  typedef struct packed {
    logic              beat;
    logic [LevelW-1:0] level;
  } abod_out_t;

  // Per-cycle control from the top level to the state blocks.
  typedef struct packed {
    logic step;       // the held word advances this cycle
    logic frame_end;  // the held word closes a frame
  } abod_ctl_t;

  // Magnitude of a two's complement byte; 0x80 yields 128 in 8 bits.
  function automatic logic [SampleW-1:0] byte_mag(input logic [SampleW-1:0] b);
    logic [SampleW-1:0] neg;
    neg = ~b + 8'd1;
    return b[SampleW-1] ? neg : b;
  endfunction

endpackage

[rtl/core/abod_accum.sv]
// Per-channel saturating magnitude accumulators and the frame level.
module abod_accum import abod_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  abod_ctl_t         ctl,
  input  abod_in_t          word,
  output logic [LevelW-1:0] level
);

  logic [LevelW-1:0] left_sum_r, left_sum_nxt;
  logic [LevelW-1:0] right_sum_r, right_sum_nxt;
  logic [LevelW:0]   left_add, right_add;
  logic [LevelW-1:0] left_tot, right_tot;

  // Add magnitudes with saturation
  always_comb begin
    left_add  = {1'b0, left_sum_r} + {{(LevelW+1-SampleW){1'b0}}, byte_mag(word.left_sample)};
    right_add = {1'b0, right_sum_r} + {{(LevelW+1-SampleW){1'b0}}, byte_mag(word.right_sample)};
    left_tot  = (left_add > {1'b0, SumMax}) ? SumMax : left_add[LevelW-1:0];
    right_tot = (right_add > {1'b0, SumMax}) ? SumMax : right_add[LevelW-1:0];
  end

  // Frame level is the larger sum, this word included
  assign level = (left_tot > right_tot) ? left_tot : right_tot;

  // Advance sums; clear them when the frame closes
  always_comb begin
    left_sum_nxt  = left_sum_r;
    right_sum_nxt = right_sum_r;
    if (ctl.step) begin
      if (ctl.frame_end) begin
        left_sum_nxt  = '0;
        right_sum_nxt = '0;
      end else begin
        left_sum_nxt  = left_tot;
        right_sum_nxt = right_tot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_sum_r  <= '0;
      right_sum_r <= '0;
    end else begin
      left_sum_r  <= left_sum_nxt;
      right_sum_r <= right_sum_nxt;
    end
  end

endmodule

[rtl/core/abod_peak.sv]
// Smoothed peak, decaying peak hold and last beat level; beat decision.
module abod_peak import abod_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  abod_ctl_t         ctl,
  input  logic [LevelW-1:0] level,
  input  logic [LevelW-1:0] min_level,
  output logic              beat
);

  logic [LevelW-1:0] smoothed_r, smoothed_nxt;
  logic [LevelW-1:0] hold_r, hold_nxt;
  logic [LevelW-1:0] last_beat_r, last_beat_nxt;

  logic [23:0]       blend;
  logic [LevelW-1:0] smoothed_mid;
  logic [22:0]       scaled;
  logic [LevelW:0]   thresh;
  logic [LevelW:0]   avg_sum;
  logic [20:0]       decay;

  // Blend smoothed peak toward hold: (sp*125 + ph*3) / 128
  always_comb begin
    blend = ({7'd0, smoothed_r} << 7) - ({7'd0, smoothed_r} << 1) - {7'd0, smoothed_r}
          + ({7'd0, hold_r} << 1) + {7'd0, hold_r};
    smoothed_mid = blend[23:7];
    // Threshold sp*34/32, kept at full width
    scaled = ({6'd0, smoothed_mid} << 5) + ({6'd0, smoothed_mid} << 1);
    thresh = scaled[22:5];
    avg_sum = {1'b0, level} + {1'b0, last_beat_r};
    decay = ({4'd0, hold_r} << 4) - ({4'd0, hold_r} << 1);
  end

  assign beat = ({1'b0, level} >= thresh) && (level > min_level);

  // Update peak state on frame close
  always_comb begin
    smoothed_nxt  = smoothed_r;
    hold_nxt      = hold_r;
    last_beat_nxt = last_beat_r;
    if (ctl.step && ctl.frame_end) begin
      smoothed_nxt = smoothed_mid;
      if (beat) begin
        smoothed_nxt  = avg_sum[LevelW:1];
        last_beat_nxt = level;
      end else if (level > hold_r) begin
        hold_nxt = level;
      end else begin
        hold_nxt = decay[20:4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r  <= '0;
      hold_r      <= '0;
      last_beat_r <= '0;
    end else begin
      smoothed_r  <= smoothed_nxt;
      hold_r      <= hold_nxt;
      last_beat_r <= last_beat_nxt;
    end
  end

endmodule

[rtl/core/audio_beat_onset_detector.sv]
// Top level of the beat onset detector: handshake, input and result registers.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_data (abod_in_t)
//   out     | output    | out_valid/out_stall | out_data (abod_out_t)
//   cfg     | input     | cfg_wr_en           | cfg_wr_data (min_level)
//
// One word per cycle is accepted while in_stall is low and is held in the input
// register; the sums and, for a frame-closing word, the result register load
// from it when the word advances, so a frame result passes through the input
// register and then the result register, which loads with out_valid.
// Reset (synchronous, rst_n low) clears all sums and peak state and sets
// min_level to 9216. A stalled result blocks only a frame-closing word;
// other words keep advancing into the sums.
module audio_beat_onset_detector import abod_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  abod_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output abod_out_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [LevelW-1:0] cfg_wr_data
);

  abod_in_t          word_r;
  logic              word_valid_r, word_valid_nxt;
  abod_out_t         out_r;
  logic              out_valid_r, out_valid_nxt;
  logic [LevelW-1:0] min_level_r;
  logic              in_fire;
  logic              adv;
  abod_ctl_t         ctl;
  logic [LevelW-1:0] level;
  logic              beat;

  // Advance the held word unless it closes a frame and the result slot is blocked
  assign adv = word_valid_r && (!word_r.frame_end || !out_valid_r || !out_stall);
  assign in_stall = word_valid_r && !adv;
  assign in_fire = in_valid && !in_stall;
  assign ctl = '{step: adv, frame_end: word_r.frame_end};

  abod_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .word  (word_r),
    .level (level)
  );

  abod_peak u_peak (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .level     (level),
    .min_level (min_level_r),
    .beat      (beat)
  );

  // Hold valid flags
  always_comb begin
    word_valid_nxt = in_fire ? 1'b1 : (adv ? 1'b0 : word_valid_r);
    out_valid_nxt  = (adv && word_r.frame_end) ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      min_level_r  <= MinLevelReset;
    end else begin
      word_valid_r <= word_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        min_level_r <= cfg_wr_data;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_r <= in_data;
    end
    if (adv && word_r.frame_end) begin
      out_r <= '{beat: beat, level: level};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A stall is raised only while a word is held
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> word_valid_r)
    else $error("input stalled with no word held");

  // A frame result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("pending result lost");

  // A result appears only from a frame-closing word
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !(adv && word_r.frame_end)) |=> !out_valid_r)
    else $error("result without frame close");

endmodule
